[design/wdrs_pkg.sv]
// Shared field widths, codes and beat layout for the device run selector.
package wdrs_pkg;

  localparam int IDX_FIELD_W = 4;
  localparam int ID_FIELD_W  = 16;
  localparam int COUNT_W     = 5;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_BUILD = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0]    count;
    logic [ID_FIELD_W-1:0] start_id;
  } build_req_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] device_index;
    logic                   fail;
    logic                   last;
  } result_t;

endpackage

[design/wdrs_id_mem.sv]
// Device id memory with registered read, plus per-entry valid flags.
module wdrs_id_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int ID_W  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ID_W-1:0]  wr_id,
  input  logic             wr_valid,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ID_W-1:0]  rd_id,
  output logic             rd_valid
);

  logic [ID_W-1:0]  mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [ID_W-1:0]  rd_id_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_id;
    end
    if (rd_en) begin
      rd_id_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= wr_valid;
      end
      if (rd_en) begin
        rd_valid_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_id    = rd_id_r;
  assign rd_valid = rd_valid_r;

endmodule

[design/wdrs_seq.sv]
// Build sequencer: id range scan, per-id table search and result register.
module wdrs_seq #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 5,
  parameter int ID_W  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CNT_W-1:0]    n_active,
  input  logic                build_go,
  input  wdrs_pkg::build_req_t build_req,
  output logic                idle,
  output logic                rd_en,
  output logic [IDX_W-1:0]    rd_addr,
  input  logic [ID_W-1:0]     rd_id,
  input  logic                rd_valid,
  output logic                res_valid,
  output wdrs_pkg::result_t   res,
  input  logic                res_ready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANGE,
    ST_SRCH,
    ST_EMIT
  } state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             issue_r;
  logic [CNT_W-1:0]             rd_idx_r;
  logic                         rd_vld_r;
  logic [wdrs_pkg::COUNT_W-1:0] remain_r;
  logic [ID_W-1:0]              cur_r;
  logic [ID_W-1:0]              lo_r;
  logic [ID_W-1:0]              hi_r;
  logic [IDX_W-1:0]             hit_idx_r;
  logic                         hit_fail_r;
  logic                         res_valid_r;
  wdrs_pkg::result_t            res_r;

  logic [CNT_W-1:0] last_idx;
  logic             slot_free;
  logic             bad_count;

  assign last_idx  = CNT_W'(n_active - 1'b1);
  assign slot_free = !res_valid_r || res_ready;
  assign bad_count = (build_req.count == '0) ||
                     (32'(build_req.count) > 32'(n_active));

  assign idle      = (state_r == ST_IDLE);
  assign rd_en     = ((state_r == ST_RANGE) || (state_r == ST_SRCH)) && (issue_r < n_active);
  assign rd_addr   = issue_r[IDX_W-1:0];
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      res_valid_r <= 1'b0;
      issue_r     <= '0;
    end else begin
      rd_vld_r <= rd_en;
      rd_idx_r <= issue_r;
      if (rd_en) begin
        issue_r <= issue_r + 1'b1;
      end
      if ((state_r == ST_EMIT) && slot_free) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (build_go) begin
            remain_r <= build_req.count;
            cur_r    <= ID_W'(build_req.start_id);
            issue_r  <= '0;
            if (bad_count) begin
              hit_fail_r <= 1'b1;
              state_r    <= ST_EMIT;
            end else begin
              state_r <= ST_RANGE;
            end
          end
        end
        ST_RANGE: begin
          if (rd_vld_r) begin
            if (rd_idx_r == '0) begin
              lo_r <= rd_id;
              hi_r <= rd_id;
            end else begin
              if (rd_id < lo_r) lo_r <= rd_id;
              if (rd_id > hi_r) hi_r <= rd_id;
            end
            if (rd_idx_r == last_idx) begin
              issue_r <= '0;
              state_r <= ST_SRCH;
            end
          end
        end
        ST_SRCH: begin
          if (rd_vld_r) begin
            if (rd_valid && (rd_id == cur_r)) begin
              hit_idx_r  <= rd_idx_r[IDX_W-1:0];
              hit_fail_r <= 1'b0;
              state_r    <= ST_EMIT;
            end else if (rd_idx_r == last_idx) begin
              hit_fail_r <= 1'b1;
              state_r    <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (hit_fail_r) begin
              res_r.device_index <= '0;
              res_r.fail         <= 1'b1;
              res_r.last         <= 1'b1;
              state_r            <= ST_IDLE;
            end else begin
              res_r.device_index <= wdrs_pkg::IDX_FIELD_W'(hit_idx_r);
              res_r.fail         <= 1'b0;
              res_r.last         <= (remain_r == 5'd1);
              if (remain_r == 5'd1) begin
                state_r <= ST_IDLE;
              end else begin
                remain_r <= remain_r - 1'b1;
                cur_r    <= (cur_r == hi_r) ? lo_r : cur_r + 1'b1;
                issue_r  <= '0;
                state_r  <= ST_SRCH;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.fail |-> res_r.last && (res_r.device_index == '0))
    else $error("fail result without last or with nonzero index");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RANGE || state_r == ST_SRCH) |-> issue_r <= n_active)
    else $error("read issue ran past active count");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && !hit_fail_r |-> 32'(hit_idx_r) < 32'(n_active))
    else $error("hit index outside active entries");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !rd_en)
    else $error("memory read while idle");

  a_emit_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && slot_free |=> res_valid_r)
    else $error("result not registered on emit");
`endif

endmodule

[design/wrapping_device_run_select_unit.sv]
// Top level of the wrapping device run selector: ports, config and beat decode.
//
//   channel | dir | handshake             | contents
//   in_     | in  | in_tvalid/in_tready   | tuser func; tdata entry and build fields
//   out_    | out | out_tvalid/out_tready | tdata device_index; tuser fail; tlast last
//   cfg_    | in  | cfg_wr_en             | active_devices
//
// Load beat writes one entry if its index is in range. Build beat: an id range scan
// over the n active entries, then a table search per requested device, each through the single read
// port of the id memory. Invalid count (zero or above n): goes straight to a fail result.
// Reset clears valid flags and active count at once; no clearing pass.
// Results sit in an output register; the sequencer holds while it is full.
module wrapping_device_run_select_unit #(
  parameter int MAX_DEVICES = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [3:0] entry_index, [19:4] entry_id, [20] entry_valid,
  // [25:21] request_count, [41:26] start_id, [47:42] zero
  input  logic [wdrs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] device_index, [7:4] zero
  output logic [wdrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] fail
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [wdrs_pkg::COUNT_W-1:0]     cfg_wr_data
);

  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W = $clog2(MAX_DEVICES + 1);

  logic [wdrs_pkg::COUNT_W-1:0]     active_r;
  logic [CNT_W-1:0]                 n_active;
  logic                             in_fire;
  logic                             idle;
  logic [wdrs_pkg::IDX_FIELD_W-1:0] f_index;
  logic [wdrs_pkg::ID_FIELD_W-1:0]  f_id;
  logic                             f_valid;
  wdrs_pkg::build_req_t             build_req;
  logic                             wr_en;
  logic                             rd_en;
  logic [IDX_W-1:0]                 rd_addr;
  logic [ID_WIDTH-1:0]              rd_id;
  logic                             rd_valid;
  wdrs_pkg::result_t                res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (32'(active_r) > 32'(MAX_DEVICES)) begin
      n_active = CNT_W'(MAX_DEVICES);
    end else begin
      n_active = CNT_W'(active_r);
    end
  end

  assign in_tready          = idle;
  assign in_fire            = in_tvalid && in_tready;
  assign f_index            = in_tdata[3:0];
  assign f_id               = in_tdata[19:4];
  assign f_valid            = in_tdata[20];
  assign build_req.count    = in_tdata[25:21];
  assign build_req.start_id = in_tdata[41:26];
  assign wr_en              = in_fire && (in_tuser == wdrs_pkg::FUNC_LOAD) &&
                              (32'(f_index) < 32'(MAX_DEVICES));

  wdrs_id_mem #(
    .DEPTH (MAX_DEVICES),
    .IDX_W (IDX_W),
    .ID_W  (ID_WIDTH)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (IDX_W'(f_index)),
    .wr_id    (ID_WIDTH'(f_id)),
    .wr_valid (f_valid),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_id    (rd_id),
    .rd_valid (rd_valid)
  );

  wdrs_seq #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W),
    .ID_W  (ID_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_active  (n_active),
    .build_go  (in_fire && (in_tuser == wdrs_pkg::FUNC_BUILD)),
    .build_req (build_req),
    .idle      (idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_id     (rd_id),
    .rd_valid  (rd_valid),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {{(wdrs_pkg::OUT_TDATA_W - wdrs_pkg::IDX_FIELD_W){1'b0}},
                      res.device_index};
  assign out_tuser = res.fail;
  assign out_tlast = res.last;

endmodule
